### hdl/tga_rle_pkg.sv
// ----------------------------------------------------------------------------
// TGA pixel decoder package
// Shared types, register indexes and constants for the TGA pixel-data decoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [1:0] CSR_RUN_LENGTH_MODE = 2'd1;
   localparam logic [1:0] CSR_PIXEL_TOTAL     = 2'd2;

   // Register reset values.
   localparam logic [2:0]  BPP_RESET         = 3'd3;
   localparam logic        RLE_MODE_RESET    = 1'b0;
   localparam logic [31:0] PIXEL_TOTAL_RESET = 32'd0;

   // Packet header fields.
   localparam logic [7:0] PKT_RUN_FLAG  = 8'h80;
   localparam logic [7:0] PKT_COUNT_MSK = 8'h7f;

   // ARGB1555 masks.
   localparam logic [7:0] A1555_RED_MSK   = 8'h7c;
   localparam logic [7:0] A1555_GHI_MSK   = 8'h03;
   localparam logic [7:0] A1555_GLO_MSK   = 8'he0;
   localparam logic [7:0] A1555_BLUE_MSK  = 8'h1f;
   localparam logic [7:0] A1555_ALPHA_MSK = 8'h80;
   localparam logic [7:0] ALPHA_OPAQUE    = 8'd255;

   // Default depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Stored pixel size after clamping.
   typedef enum logic [1:0] {
      PIX_SIZE_2 = 2'd0,
      PIX_SIZE_3 = 2'd1,
      PIX_SIZE_4 = 2'd2
   } pix_size_type;

   // One finished pixel as handed from the front to the back.
   typedef struct packed {
      logic [7:0]   byte3;
      logic [7:0]   byte2;
      logic [7:0]   byte1;
      logic [7:0]   byte0;
      pix_size_type size;
      logic [7:0]   repeat_count;
      logic         image_done;
      logic         run_clipped;
   } pixel_cmd_type;

endpackage

### hdl/tga_rle_front.sv
// ----------------------------------------------------------------------------
// TGA decoder front end
// Accepts pixel-data bytes, tracks packet and pixel phase, counts pixels and
// emits one command per finished pixel or run.
// ----------------------------------------------------------------------------
module tga_rle_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       byte_accept,
   input  logic [7:0]                 data_byte,
   input  logic                       image_start,
   input  logic [2:0]                 bytes_per_pixel,
   input  logic                       run_length_mode,
   input  logic [31:0]                pixel_total,
   output logic                       cmd_push,
   output tga_rle_pkg::pixel_cmd_type cmd
);

   logic [2:0]  byte_phase_ff, byte_phase_in;
   logic [23:0] partial_ff, partial_in;
   logic        is_run_ff, is_run_in;
   logic        await_hdr_ff, await_hdr_in;
   logic [7:0]  pkt_left_ff, pkt_left_in;
   logic [31:0] emitted_ff, emitted_in;
   logic        finished_ff, finished_in;

   // State as seen after an optional restart by image_start.
   logic [2:0]  phase_eff;
   logic [23:0] partial_eff;
   logic        is_run_eff;
   logic        await_eff;
   logic [7:0]  left_eff;
   logic [31:0] emitted_eff;
   logic        finished_eff;

   logic [32:0] diff;
   logic [31:0] remaining;
   logic        image_full;
   logic [3:0]  size_num;
   logic [3:0]  phase_next;
   tga_rle_pkg::pix_size_type size_code;
   logic [7:0]  repeat_raw;
   logic        reach_end;
   logic        partial_pixel;
   logic [7:0]  b0, b1, b2, b3;

   always_comb begin
      if (image_start) begin
         phase_eff    = 3'd0;
         partial_eff  = 24'd0;
         is_run_eff   = 1'b0;
         await_eff    = 1'b1;
         left_eff     = 8'd0;
         emitted_eff  = 32'd0;
         finished_eff = 1'b0;
      end else begin
         phase_eff    = byte_phase_ff;
         partial_eff  = partial_ff;
         is_run_eff   = is_run_ff;
         await_eff    = await_hdr_ff;
         left_eff     = pkt_left_ff;
         emitted_eff  = emitted_ff;
         finished_eff = finished_ff;
      end
   end

   // Pixels still to come before the image total.
   assign diff       = {1'b0, pixel_total} - {1'b0, emitted_eff};
   assign remaining  = diff[31:0];
   assign image_full = finished_eff | diff[32] | (remaining == 32'd0);

   // Clamp the configured pixel size to 2..4.
   always_comb begin
      if (bytes_per_pixel < 3'd3) begin
         size_num  = 4'd2;
         size_code = tga_rle_pkg::PIX_SIZE_2;
      end else if (bytes_per_pixel == 3'd3) begin
         size_num  = 4'd3;
         size_code = tga_rle_pkg::PIX_SIZE_3;
      end else begin
         size_num  = 4'd4;
         size_code = tga_rle_pkg::PIX_SIZE_4;
      end
   end

   assign phase_next    = {1'b0, phase_eff} + 4'd1;
   assign partial_pixel = phase_next < size_num;

   // Repeat count before clipping at the image end.
   always_comb begin
      if (run_length_mode && is_run_eff) begin
         repeat_raw = (left_eff == 8'd0) ? 8'd1 : left_eff;
      end else begin
         repeat_raw = 8'd1;
      end
   end

   assign reach_end = {24'd0, repeat_raw} >= remaining;

   // Bytes of the finished pixel, the last one taken straight from the input.
   always_comb begin
      b0 = partial_eff[7:0];
      b1 = partial_eff[15:8];
      b2 = partial_eff[23:16];
      b3 = 8'd0;
      case (phase_eff)
         3'd0:    b0 = data_byte;
         3'd1:    b1 = data_byte;
         3'd2:    b2 = data_byte;
         3'd3:    b3 = data_byte;
         default: ;
      endcase
   end

   // Next state and command.
   always_comb begin
      byte_phase_in = byte_phase_ff;
      partial_in    = partial_ff;
      is_run_in     = is_run_ff;
      await_hdr_in  = await_hdr_ff;
      pkt_left_in   = pkt_left_ff;
      emitted_in    = emitted_ff;
      finished_in   = finished_ff;
      cmd_push      = 1'b0;

      cmd.byte0        = b0;
      cmd.byte1        = b1;
      cmd.byte2        = b2;
      cmd.byte3        = b3;
      cmd.size         = size_code;
      cmd.repeat_count = reach_end ? remaining[7:0] : repeat_raw;
      cmd.image_done   = reach_end;
      cmd.run_clipped  = run_length_mode && is_run_eff && ({24'd0, repeat_raw} > remaining);

      if (byte_accept) begin
         byte_phase_in = phase_eff;
         partial_in    = partial_eff;
         is_run_in     = is_run_eff;
         await_hdr_in  = await_eff;
         pkt_left_in   = left_eff;
         emitted_in    = emitted_eff;
         finished_in   = finished_eff;

         if (image_full) begin
            // Image complete: the byte is dropped.
         end else if (run_length_mode && await_eff) begin
            is_run_in     = (data_byte & tga_rle_pkg::PKT_RUN_FLAG) != 8'd0;
            pkt_left_in   = (data_byte & tga_rle_pkg::PKT_COUNT_MSK) + 8'd1;
            await_hdr_in  = 1'b0;
            byte_phase_in = 3'd0;
            partial_in    = 24'd0;
         end else if (partial_pixel) begin
            case (phase_eff[1:0])
               2'd0:    partial_in[7:0]   = data_byte;
               2'd1:    partial_in[15:8]  = data_byte;
               2'd2:    partial_in[23:16] = data_byte;
               default: ;
            endcase
            byte_phase_in = phase_next[2:0];
         end else begin
            byte_phase_in = 3'd0;
            partial_in    = 24'd0;
            cmd_push      = 1'b1;
            if (run_length_mode) begin
               if (is_run_eff) begin
                  pkt_left_in  = 8'd0;
                  await_hdr_in = 1'b1;
               end else begin
                  if (left_eff > 8'd1) begin
                     pkt_left_in = left_eff - 8'd1;
                  end else begin
                     pkt_left_in  = 8'd0;
                     await_hdr_in = 1'b1;
                  end
               end
            end
            emitted_in  = reach_end ? pixel_total : emitted_eff + {24'd0, repeat_raw};
            finished_in = reach_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_phase_ff <= 3'd0;
         partial_ff    <= 24'd0;
         is_run_ff     <= 1'b0;
         await_hdr_ff  <= 1'b1;
         pkt_left_ff   <= 8'd0;
         emitted_ff    <= 32'd0;
         finished_ff   <= 1'b0;
      end else begin
         byte_phase_ff <= byte_phase_in;
         partial_ff    <= partial_in;
         is_run_ff     <= is_run_in;
         await_hdr_ff  <= await_hdr_in;
         pkt_left_ff   <= pkt_left_in;
         emitted_ff    <= emitted_in;
         finished_ff   <= finished_in;
      end
   end

endmodule

### hdl/tga_rle_queue.sv
// ----------------------------------------------------------------------------
// TGA decoder command queue
// Small first-in first-out store of pixel commands between front and back.
// ----------------------------------------------------------------------------
module tga_rle_queue #(
   parameter int Depth = tga_rle_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tga_rle_pkg::pixel_cmd_type push_cmd,
   output logic                       full,
   input  logic                       pop,
   output logic                       head_valid,
   output tga_rle_pkg::pixel_cmd_type head_cmd
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   tga_rle_pkg::pixel_cmd_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = count_ff == FullCnt;
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hdl/tga_rle_back.sv
// ----------------------------------------------------------------------------
// TGA decoder back end
// Widens stored pixel bytes to RGBA and holds the result in an output register.
// ----------------------------------------------------------------------------
module tga_rle_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  tga_rle_pkg::pixel_cmd_type head_cmd,
   output logic                       head_pop,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [39:0]                out_data,
   output logic [1:0]                 out_user
);

   logic        valid_ff, valid_in;
   logic [39:0] data_ff, data_in;
   logic [1:0]  user_ff, user_in;
   logic [7:0]  red, green, blue, alpha;

   // Channel widening per stored pixel size.
   always_comb begin
      unique case (head_cmd.size)
         tga_rle_pkg::PIX_SIZE_2: begin
            red   = (head_cmd.byte1 & tga_rle_pkg::A1555_RED_MSK) << 1;
            green = ((head_cmd.byte1 & tga_rle_pkg::A1555_GHI_MSK) << 6)
                  | ((head_cmd.byte0 & tga_rle_pkg::A1555_GLO_MSK) >> 2);
            blue  = (head_cmd.byte0 & tga_rle_pkg::A1555_BLUE_MSK) << 3;
            alpha = head_cmd.byte1 & tga_rle_pkg::A1555_ALPHA_MSK;
         end
         tga_rle_pkg::PIX_SIZE_3: begin
            red   = head_cmd.byte2;
            green = head_cmd.byte1;
            blue  = head_cmd.byte0;
            alpha = tga_rle_pkg::ALPHA_OPAQUE;
         end
         default: begin
            red   = head_cmd.byte2;
            green = head_cmd.byte1;
            blue  = head_cmd.byte0;
            alpha = head_cmd.byte3;
         end
      endcase
   end

   // Load the output register whenever it is empty or being drained.
   assign head_pop = head_valid && (!valid_ff || out_ready);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      user_in  = user_ff;
      if (head_pop) begin
         valid_in = 1'b1;
         data_in  = {head_cmd.repeat_count, alpha, blue, green, red};
         user_in  = {head_cmd.run_clipped, head_cmd.image_done};
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_user  = user_ff;

endmodule

### hdl/tga_pixel_rle_decoder_unit.sv
// ----------------------------------------------------------------------------
// TGA pixel-data decoder
// Decodes uncompressed or run-length coded TGA pixel bytes into RGBA results.
// ----------------------------------------------------------------------------
// The block takes one pixel-data byte per cycle on the request side, while
// the command queue has room, and gives one RGBA result per finished pixel,
// or one result with a repeat count per run packet. The packet, phase and
// pixel-count updates all finish in the cycle of acceptance, so a sustained
// rate of one byte per clock is kept as long as results are taken. A result
// passes through the command queue and then the output register. The queue
// lets the byte side keep running while a result waits to be taken.
module tga_pixel_rle_decoder_unit #(
   parameter int QueueDepth = tga_rle_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // Request bytes.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] image_start
   // Decoded pixels.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                    // [31:24] alpha, [39:32] repeat_count
   output logic        rsp_tlast,   // image_done
   output logic        rsp_tuser,   // [0] run_clipped
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [2:0]  bpp_ff, bpp_in;
   logic        rle_ff, rle_in;
   logic [31:0] total_ff, total_in;

   logic                       queue_full;
   logic                       byte_accept;
   logic                       cmd_push;
   tga_rle_pkg::pixel_cmd_type cmd;
   logic                       head_valid;
   logic                       head_pop;
   tga_rle_pkg::pixel_cmd_type head_cmd;
   logic [1:0]                 rsp_flags;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      bpp_in   = bpp_ff;
      rle_in   = rle_ff;
      total_in = total_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tga_rle_pkg::CSR_BYTES_PER_PIXEL: bpp_in   = csr_data[2:0];
            tga_rle_pkg::CSR_RUN_LENGTH_MODE: rle_in   = csr_data[0];
            tga_rle_pkg::CSR_PIXEL_TOTAL:     total_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= tga_rle_pkg::BPP_RESET;
         rle_ff   <= tga_rle_pkg::RLE_MODE_RESET;
         total_ff <= tga_rle_pkg::PIXEL_TOTAL_RESET;
      end else begin
         bpp_ff   <= bpp_in;
         rle_ff   <= rle_in;
         total_ff <= total_in;
      end
   end

   // Bytes are taken while the queue has room.
   assign req_tready  = !queue_full;
   assign byte_accept = req_tvalid && req_tready;

   tga_rle_front u_front (
      .clock           (clock),
      .reset           (reset),
      .byte_accept     (byte_accept),
      .data_byte       (req_tdata),
      .image_start     (req_tuser),
      .bytes_per_pixel (bpp_ff),
      .run_length_mode (rle_ff),
      .pixel_total     (total_ff),
      .cmd_push        (cmd_push),
      .cmd             (cmd)
   );

   tga_rle_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tga_rle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_pop   (head_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_tdata),
      .out_user   (rsp_flags)
   );

   // The image-complete flag marks the last result of a frame.
   assign rsp_tlast = rsp_flags[0];
   assign rsp_tuser = rsp_flags[1];

endmodule

### bench/tb_tga_pixel_rle_decoder_unit.sv
// ----------------------------------------------------------------------------
// TGA pixel decoder testbench
// Streams TGA pixel-data bytes into the decoder, in raw and run-length modes,
// under several register settings. A built-in predictor works out every
// decoded pixel, and each result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_tga_pixel_rle_decoder_unit;

   timeunit 1ns;
   timeprecision 1ps;

   // Index with no register behind it; writes to it must change nothing.
   localparam logic [1:0] CSR_SPARE = 2'd3;

   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 200;
   localparam int RANDOM_BYTES   = 950;
   localparam int PRESSURE_PHASE = 3;

   // One decoded pixel as seen on the result side.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_count;
      logic       image_done;
      logic       run_clipped;
   } rgba_result_type;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   // One line of the directed table: a register write or a request byte.
   typedef struct packed {
      row_kind_type    kind;
      logic [1:0]      csr_idx;
      logic [31:0]     csr_value;
      logic [7:0]      data;
      logic            start;
      logic            given;
      rgba_result_type pixel;
   } stim_row_type;

   localparam rgba_result_type NO_PIXEL = '0;

   // Directed table. Pixels are typed in where they follow directly from the
   // bytes; the other rows are checked against the predictor.
   localparam stim_row_type DIRECTED_ROWS [0:30] = '{
      // Pixel total is zero after reset, so the byte is ignored.
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'hab, 1'b1, 1'b0, NO_PIXEL},
      '{ROW_CSR,  tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd4, 8'h00, 1'b0, 1'b0, NO_PIXEL},
      // Raw BGR pixels at both extremes.
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h00, 1'b1, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h00, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h00, 1'b0, 1'b1,
        '{8'h00, 8'h00, 8'h00, 8'hff, 8'd1, 1'b0, 1'b0}},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'hff, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'hff, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'hff, 1'b0, 1'b1,
        '{8'hff, 8'hff, 8'hff, 8'hff, 8'd1, 1'b0, 1'b0}},
      // Switch to ARGB1555 mid-image; the last pixel completes the image.
      '{ROW_CSR,  tga_rle_pkg::CSR_BYTES_PER_PIXEL, 32'd2, 8'h00, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'hff, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'hff, 1'b0, 1'b1,
        '{8'hf8, 8'hf8, 8'hf8, 8'h80, 8'd1, 1'b0, 1'b0}},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h00, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h00, 1'b0, 1'b1,
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 1'b1, 1'b0}},
      // Run-length coded BGRA image of 130 pixels.
      '{ROW_CSR,  tga_rle_pkg::CSR_BYTES_PER_PIXEL, 32'd4, 8'h00, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_CSR,  tga_rle_pkg::CSR_RUN_LENGTH_MODE, 32'd1, 8'h00, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_CSR,  tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd130, 8'h00, 1'b0, 1'b0, NO_PIXEL},
      // Literal packet of one pixel.
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h00, 1'b1, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h5a, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'ha5, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h3c, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'hc3, 1'b0, 1'b0, NO_PIXEL},
      // Longest run, 128 pixels.
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'hff, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h11, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h22, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h33, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h44, 1'b0, 1'b1,
        '{8'h33, 8'h22, 8'h11, 8'h44, 8'd128, 1'b0, 1'b0}},
      // Run of three with one pixel left: clipped to one, image done.
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h82, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h01, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h02, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h03, 1'b0, 1'b0, NO_PIXEL},
      '{ROW_BYTE, tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd0, 8'h04, 1'b0, 1'b1,
        '{8'h03, 8'h02, 8'h01, 8'h04, 8'd1, 1'b1, 1'b1}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // Predictor copy of the registers and the decoding state.
   logic [2:0]  cfg_bpp   = tga_rle_pkg::BPP_RESET;
   logic        cfg_rle   = tga_rle_pkg::RLE_MODE_RESET;
   logic [31:0] cfg_total = tga_rle_pkg::PIXEL_TOTAL_RESET;
   logic [2:0]  pix_byte_idx = '0;
   logic [23:0] pix_accum    = '0;
   logic        run_packet   = 1'b0;
   logic        need_header  = 1'b1;
   logic [7:0]  packet_left  = '0;
   logic [31:0] pixels_out   = '0;
   logic        image_full   = 1'b0;

   rgba_result_type expected_pixels [$];

   int  mismatches = 0;
   int  pixels_checked = 0;
   int  clipped_seen = 0;
   int  images_done_seen = 0;
   int  bytes_sent = 0;
   int  bytes_decoded = 0;
   int  phases_run = 0;
   int  long_holds = 0;
   bit  sender_calm = 1'b0;
   bit  sink_calm = 1'b0;
   bit  hold_request = 1'b0;

   tga_pixel_rle_decoder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Safety net against a hung handshake.
   initial begin
      #10_000_000;
      $display("tb_tga_pixel_rle_decoder_unit: FAIL");
      $finish;
   end

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Stored pixel size after clamping out-of-range settings.
   function automatic tga_rle_pkg::pix_size_type clamp_size(input logic [2:0] bpp);
      if (bpp <= 3'd2) return tga_rle_pkg::PIX_SIZE_2;
      if (bpp == 3'd3) return tga_rle_pkg::PIX_SIZE_3;
      return tga_rle_pkg::PIX_SIZE_4;
   endfunction

   // Advances the predictor by one request byte. Returns 1 when the byte
   // finishes a pixel; used says whether the byte was decoded at all.
   function automatic logic decode_tga_byte(input logic [7:0] value, input logic start,
                                            output logic used,
                                            output rgba_result_type pixel);
      logic [7:0]                pb [4];
      logic [31:0]               remaining;
      logic [31:0]               reps;
      logic                      clip;
      tga_rle_pkg::pix_size_type size;
      used = 1'b0;
      pixel = '0;
      if (start) begin
         pix_byte_idx = '0;
         pix_accum = '0;
         run_packet = 1'b0;
         need_header = 1'b1;
         packet_left = '0;
         pixels_out = '0;
         image_full = 1'b0;
      end
      if (image_full || pixels_out >= cfg_total) return 1'b0;
      used = 1'b1;

      // Packet header in run-length mode.
      if (cfg_rle && need_header) begin
         run_packet = (value & tga_rle_pkg::PKT_RUN_FLAG) != 8'd0;
         packet_left = (value & tga_rle_pkg::PKT_COUNT_MSK) + 8'd1;
         need_header = 1'b0;
         pix_byte_idx = '0;
         pix_accum = '0;
         return 1'b0;
      end

      // Collect bytes until the pixel is complete.
      size = clamp_size(cfg_bpp);
      if (int'(pix_byte_idx) + 1 < int'(size) + 2) begin
         pix_accum = 24'(32'(pix_accum) | (32'(value) << (8 * int'(pix_byte_idx[1:0]))));
         pix_byte_idx = pix_byte_idx + 3'd1;
         return 1'b0;
      end

      pb[0] = pix_accum[7:0];
      pb[1] = pix_accum[15:8];
      pb[2] = pix_accum[23:16];
      pb[3] = 8'd0;
      if (pix_byte_idx < 3'd4) pb[pix_byte_idx[1:0]] = value;
      pix_byte_idx = '0;
      pix_accum = '0;

      // Repeat count, clipped at the pixel total for runs.
      remaining = cfg_total - pixels_out;
      reps = 32'd1;
      clip = 1'b0;
      if (cfg_rle) begin
         if (run_packet) begin
            reps = 32'(packet_left);
            if (reps == 32'd0) reps = 32'd1;
            if (reps > remaining) begin
               reps = remaining;
               clip = 1'b1;
            end
            packet_left = '0;
            need_header = 1'b1;
         end else begin
            if (packet_left > 8'd0) packet_left = packet_left - 8'd1;
            if (packet_left == 8'd0) need_header = 1'b1;
         end
      end
      pixels_out = pixels_out + reps;

      // Widen the stored pixel to RGBA.
      if (size == tga_rle_pkg::PIX_SIZE_2) begin
         pixel.red   = (pb[1] & tga_rle_pkg::A1555_RED_MSK) << 1;
         pixel.green = ((pb[1] & tga_rle_pkg::A1555_GHI_MSK) << 6)
                     | ((pb[0] & tga_rle_pkg::A1555_GLO_MSK) >> 2);
         pixel.blue  = (pb[0] & tga_rle_pkg::A1555_BLUE_MSK) << 3;
         pixel.alpha = pb[1] & tga_rle_pkg::A1555_ALPHA_MSK;
      end else begin
         pixel.red   = pb[2];
         pixel.green = pb[1];
         pixel.blue  = pb[0];
         pixel.alpha = (size == tga_rle_pkg::PIX_SIZE_4) ? pb[3]
                                                         : tga_rle_pkg::ALPHA_OPAQUE;
      end
      pixel.repeat_count = reps[7:0];
      pixel.image_done = (pixels_out == cfg_total);
      pixel.run_clipped = clip;
      if (pixels_out == cfg_total) image_full = 1'b1;
      return 1'b1;
   endfunction

   // Offers one request byte, after a random gap unless the sender is calm, and records what it yields.
   task automatic send_byte(input logic [7:0] value, input logic start, input logic given,
                            input rgba_result_type typed);
      int              gap;
      logic            used;
      logic            made;
      rgba_result_type predicted;
      gap = sender_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      made = decode_tga_byte(value, start, used, predicted);
      if (used) bytes_decoded++;
      if (given) expected_pixels.push_back(typed);
      else if (made) expected_pixels.push_back(predicted);
   endtask

   // Writes one register and mirrors it in the predictor.
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         tga_rle_pkg::CSR_BYTES_PER_PIXEL: cfg_bpp = value[2:0];
         tga_rle_pkg::CSR_RUN_LENGTH_MODE: cfg_rle = value[0];
         tga_rle_pkg::CSR_PIXEL_TOTAL:     cfg_total = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stops offering bytes and waits until the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random phase: new settings, then a stream of mostly well-formed
   // pixel data with occasional stray restarts.
   task automatic run_random_phase(input bit pressure);
      logic [7:0]  stream [$];
      logic [7:0]  hdr;
      logic [31:0] total;
      logic [2:0]  bpp;
      int          nbytes;
      int          pix_bytes;
      int          npix;
      bit          restart;
      logic        start;
      settle();
      sender_calm = pressure || ($urandom_range(0, 3) == 0);
      if (pressure) begin
         write_csr(tga_rle_pkg::CSR_BYTES_PER_PIXEL, 32'd2);
         write_csr(tga_rle_pkg::CSR_RUN_LENGTH_MODE, 32'd0);
         write_csr(tga_rle_pkg::CSR_PIXEL_TOTAL, 32'd100000);
         hold_request = 1'b1;
      end else begin
         if ($urandom_range(0, 2) != 0) begin
            bpp = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(2, 4));
            write_csr(tga_rle_pkg::CSR_BYTES_PER_PIXEL,
                      ($urandom & 32'hffff_fff8) | 32'(bpp));
         end
         if ($urandom_range(0, 2) != 0)
            write_csr(tga_rle_pkg::CSR_RUN_LENGTH_MODE,
                      ($urandom & 32'hffff_fffe) | 32'($urandom_range(0, 1)));
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
               0:       total = 32'd0;
               1:       total = $urandom;
               2:       total = 32'hffff_ffff;
               default: total = 32'($urandom_range(1, 40));
            endcase
            write_csr(tga_rle_pkg::CSR_PIXEL_TOTAL, total);
         end
         if ($urandom_range(0, 7) == 0) write_csr(CSR_SPARE, $urandom);
      end

      // Build the byte stream for the current settings.
      restart = pressure || ($urandom_range(0, 4) != 0);
      nbytes = pressure ? 120 : $urandom_range(8, 60);
      pix_bytes = int'(clamp_size(cfg_bpp)) + 2;
      while (stream.size() < nbytes) begin
         npix = 1;
         if (cfg_rle) begin
            hdr[7] = 1'($urandom_range(0, 1));
            hdr[6:0] = $urandom_range(0, 1) ? 7'($urandom_range(0, 7))
                                            : 7'($urandom_range(0, 127));
            stream.push_back(hdr);
            npix = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
         end
         repeat (npix * pix_bytes) stream.push_back(8'($urandom));
      end

      for (int i = 0; i < nbytes; i++) begin
         start = (i == 0 && restart) || ($urandom_range(0, 59) == 0);
         send_byte(stream[i], start, 1'b0, NO_PIXEL);
      end
      phases_run++;
   endtask

   // Result side: random stalls, calm stretches and one long hold-off.
   initial begin : result_sink
      int gap;
      wait (reset == 1'b0);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            long_holds++;
         end else begin
            gap = sink_calm ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Compare each accepted pixel with the oldest expected one.
   always @(posedge clock) begin
      rgba_result_type got;
      rgba_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.red          = rsp_tdata[7:0];
         got.green        = rsp_tdata[15:8];
         got.blue         = rsp_tdata[23:16];
         got.alpha        = rsp_tdata[31:24];
         got.repeat_count = rsp_tdata[39:32];
         got.image_done   = rsp_tlast;
         got.run_clipped  = rsp_tuser;
         if (expected_pixels.size() == 0) begin
            report_mismatch("pixel with none expected", rsp_tdata[31:0], 32'd0);
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (want.run_clipped) clipped_seen++;
            if (want.image_done) images_done_seen++;
            if (got.red != want.red)
               report_mismatch("red", 32'(got.red), 32'(want.red));
            if (got.green != want.green)
               report_mismatch("green", 32'(got.green), 32'(want.green));
            if (got.blue != want.blue)
               report_mismatch("blue", 32'(got.blue), 32'(want.blue));
            if (got.alpha != want.alpha)
               report_mismatch("alpha", 32'(got.alpha), 32'(want.alpha));
            if (got.repeat_count != want.repeat_count)
               report_mismatch("repeat_count", 32'(got.repeat_count),
                               32'(want.repeat_count));
            if (got.image_done != want.image_done)
               report_mismatch("image_done", 32'(got.image_done), 32'(want.image_done));
            if (got.run_clipped != want.run_clipped)
               report_mismatch("run_clipped", 32'(got.run_clipped),
                               32'(want.run_clipped));
         end
      end
   end

   // Main sequence: reset, directed table, random phases, final check.
   initial begin : stimulus
      int first_random;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_CSR) begin
            settle();
            write_csr(DIRECTED_ROWS[i].csr_idx, DIRECTED_ROWS[i].csr_value);
         end else begin
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].start,
                      DIRECTED_ROWS[i].given, DIRECTED_ROWS[i].pixel);
         end
      end

      first_random = bytes_sent;
      while (bytes_sent - first_random < RANDOM_BYTES)
         run_random_phase(phases_run == PRESSURE_PHASE);

      settle();
      repeat (20) @(posedge clock);
      if (expected_pixels.size() != 0)
         report_mismatch("pixels never delivered", 32'(expected_pixels.size()), 32'd0);

      $display("Sent %0d bytes (%0d decoded) over %0d setting phases and %0d long stalls.",
               bytes_sent, bytes_decoded, phases_run, long_holds);
      $display("Checked %0d pixels: %0d clipped runs, %0d completed images, %0d errors.",
               pixels_checked, clipped_seen, images_done_seen, mismatches);
      if (mismatches == 0) begin
         $display("tb_tga_pixel_rle_decoder_unit: PASS");
      end else begin
         $display("tb_tga_pixel_rle_decoder_unit: FAIL");
      end
      $finish;
   end

endmodule
